@@ sv/cfr_pkg.sv @@
// Package with the types and codes shared by the command frame receiver.
`timescale 1ns / 1ps

package cfr_pkg;

	// Parser phases, one-hot.
	typedef enum logic [6:0] {
		PH_HUNT   = 7'b0000001,
		PH_SEQ    = 7'b0000010,
		PH_LEN_HI = 7'b0000100,
		PH_LEN_LO = 7'b0001000,
		PH_TOKEN  = 7'b0010000,
		PH_BODY   = 7'b0100000,
		PH_SUM    = 7'b1000000
	} phase_t;

	// Result kinds.
	localparam logic [1:0] KIND_BODY  = 2'd0;
	localparam logic [1:0] KIND_FRAME = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Error codes.
	localparam logic [1:0] ERR_START  = 2'd0;
	localparam logic [1:0] ERR_SEQ    = 2'd1;
	localparam logic [1:0] ERR_LENGTH = 2'd2;
	localparam logic [1:0] ERR_TOKEN  = 2'd3;

	// Sequence modes; the unused code behaves as ignore.
	localparam logic [1:0] SEQ_IGNORE = 2'd0;
	localparam logic [1:0] SEQ_ECHO   = 2'd1;
	localparam logic [1:0] SEQ_TEST   = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_SEQ_MODE = 2'd0;
	localparam logic [1:0] REG_START    = 2'd1;
	localparam logic [1:0] REG_TOKEN    = 2'd2;
	localparam logic [1:0] REG_MAX_LEN  = 2'd3;

	// Configuration reset values.
	localparam logic [7:0]  START_RESET   = 8'd27;
	localparam logic [7:0]  TOKEN_RESET   = 8'd14;
	localparam logic [15:0] MAX_LEN_RESET = 16'd275;

endpackage

@@ sv/command_frame_receiver.sv @@
// Command frame receiver: parses framed serial bytes into body, frame end and error words.
`timescale 1ns / 1ps
// A byte word is held in the input register, then its result word in the result register;
// bytes that give no result simply update the parser.
// Throughput: one byte word per cycle, set by the single parser update between the two
// registers; the input side stalls only while a finished result waits on a stalled output.
// Reset: arst_n clears the parser to hunting, all counters, checksum and sequence state,
// and loads the configuration registers with their default values.

module command_frame_receiver
	import cfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	// Configuration write port.
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data,

	// Input channel: one received byte per word.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,

	// Output channel: one result per word.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  body_byte,
	output logic [15:0] body_index,
	output logic [15:0] frame_length,
	output logic        checksum_good,
	output logic [1:0]  error_code,
	output logic [7:0]  frame_sequence
);

	// Configuration registers.
	logic [1:0]  seq_mode_q;
	logic [7:0]  start_marker_q;
	logic [7:0]  token_marker_q;
	logic [15:0] max_len_q;

	// Input register stage.
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// Parser state.
	phase_t      phase_q;
	logic [7:0]  exp_seq_q;
	logic [15:0] body_len_q;
	logic [15:0] seen_q;
	logic [7:0]  xor_q;
	logic [7:0]  rx_seq_q;

	// Result register.
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  bbyte_q;
	logic [15:0] bidx_q;
	logic [15:0] flen_q;
	logic        good_q;
	logic [1:0]  err_q;
	logic [7:0]  fseq_q;

	// Next-state and result logic.
	phase_t      phase_d;
	logic [7:0]  exp_seq_d;
	logic [15:0] body_len_d;
	logic [15:0] seen_d;
	logic [7:0]  xor_d;
	logic [7:0]  rx_seq_d;
	logic        res_valid;
	logic [1:0]  res_kind;
	logic [7:0]  res_byte;
	logic [15:0] res_idx;
	logic [15:0] res_len;
	logic        res_good;
	logic [1:0]  res_err;
	logic [7:0]  res_seq;
	logic [15:0] full_len;
	logic [15:0] seen_inc;

	logic s1_go;
	logic in_accept;

	// The byte in stage one moves on whenever the result register can take a word.
	assign s1_go     = ~out_valid_q | ~out_stall;
	assign in_stall  = valid_s1 & ~s1_go;
	assign in_accept = in_valid & ~in_stall;

	assign full_len = {body_len_q[15:8], byte_s1};
	assign seen_inc = seen_q + 16'd1;

	always_comb begin
		phase_d    = phase_q;
		exp_seq_d  = exp_seq_q;
		body_len_d = body_len_q;
		seen_d     = seen_q;
		xor_d      = xor_q;
		rx_seq_d   = rx_seq_q;
		res_valid  = 1'b0;
		res_kind   = KIND_BODY;
		res_byte   = 8'd0;
		res_idx    = 16'd0;
		res_len    = 16'd0;
		res_good   = 1'b0;
		res_err    = ERR_START;
		res_seq    = 8'd0;
		case (phase_q)
			PH_SEQ: begin
				rx_seq_d = byte_s1;
				xor_d    = xor_q ^ byte_s1;
				phase_d  = PH_LEN_HI;
				if (seq_mode_q == SEQ_ECHO) begin
					exp_seq_d = byte_s1;
				end else if (seq_mode_q == SEQ_TEST) begin
					if (byte_s1 != exp_seq_q) begin
						// Mismatch leaves the expected number where it was.
						phase_d   = PH_HUNT;
						res_valid = 1'b1;
						res_kind  = KIND_ERROR;
						res_err   = ERR_SEQ;
						res_seq   = byte_s1;
					end else begin
						exp_seq_d = exp_seq_q + 8'd1;
					end
				end
			end
			PH_LEN_HI: begin
				body_len_d = {byte_s1, 8'd0};
				xor_d      = xor_q ^ byte_s1;
				phase_d    = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				body_len_d = full_len;
				xor_d      = xor_q ^ byte_s1;
				phase_d    = PH_TOKEN;
				if (full_len > max_len_q) begin
					phase_d   = PH_HUNT;
					res_valid = 1'b1;
					res_kind  = KIND_ERROR;
					res_err   = ERR_LENGTH;
					res_len   = full_len;
					res_seq   = rx_seq_q;
				end
			end
			PH_TOKEN: begin
				if (byte_s1 != token_marker_q) begin
					phase_d   = PH_HUNT;
					res_valid = 1'b1;
					res_kind  = KIND_ERROR;
					res_err   = ERR_TOKEN;
					res_len   = body_len_q;
					res_seq   = rx_seq_q;
				end else begin
					xor_d  = xor_q ^ byte_s1;
					seen_d = 16'd0;
					// An empty body goes straight to the checksum byte.
					phase_d = (body_len_q == 16'd0) ? PH_SUM : PH_BODY;
				end
			end
			PH_BODY: begin
				xor_d     = xor_q ^ byte_s1;
				res_valid = 1'b1;
				res_kind  = KIND_BODY;
				res_byte  = byte_s1;
				res_idx   = seen_q;
				seen_d    = seen_inc;
				if (seen_inc >= body_len_q) begin
					phase_d = PH_SUM;
				end
			end
			PH_SUM: begin
				phase_d   = PH_HUNT;
				res_valid = 1'b1;
				res_kind  = KIND_FRAME;
				res_len   = body_len_q;
				res_good  = (byte_s1 == xor_q);
				res_seq   = rx_seq_q;
			end
			default: begin
				// Hunting, and any phase code that should never occur.
				phase_d = PH_HUNT;
				if (byte_s1 != start_marker_q) begin
					res_valid = 1'b1;
					res_kind  = KIND_ERROR;
					res_err   = ERR_START;
				end else begin
					xor_d      = byte_s1;
					body_len_d = 16'd0;
					seen_d     = 16'd0;
					rx_seq_d   = 8'd0;
					phase_d    = PH_SEQ;
				end
			end
		endcase
	end

	// Configuration registers. The user must write only while the block is idle; it is not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_mode_q     <= SEQ_IGNORE;
			start_marker_q <= START_RESET;
			token_marker_q <= TOKEN_RESET;
			max_len_q      <= MAX_LEN_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_SEQ_MODE: seq_mode_q     <= wr_data[1:0];
				REG_START:    start_marker_q <= wr_data[7:0];
				REG_TOKEN:    token_marker_q <= wr_data[7:0];
				REG_MAX_LEN:  max_len_q      <= wr_data;
				default:      ;
			endcase
		end
	end

	// Input register and parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			phase_q    <= PH_HUNT;
			exp_seq_q  <= 8'd0;
			body_len_q <= 16'd0;
			seen_q     <= 16'd0;
			xor_q      <= 8'd0;
			rx_seq_q   <= 8'd0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && s1_go) begin
				phase_q    <= phase_d;
				exp_seq_q  <= exp_seq_d;
				body_len_q <= body_len_d;
				seen_q     <= seen_d;
				xor_q      <= xor_d;
				rx_seq_q   <= rx_seq_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= rx_byte;
		end
	end

	// Result register: loads when stage one moves on, holds while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= valid_s1 & res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && valid_s1 && res_valid) begin
			kind_q  <= res_kind;
			bbyte_q <= res_byte;
			bidx_q  <= res_idx;
			flen_q  <= res_len;
			good_q  <= res_good;
			err_q   <= res_err;
			fseq_q  <= res_seq;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = kind_q;
	assign body_byte      = bbyte_q;
	assign body_index     = bidx_q;
	assign frame_length   = flen_q;
	assign checksum_good  = good_q;
	assign error_code     = err_q;
	assign frame_sequence = fseq_q;

endmodule
